[rtl/core/c2d_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// c2d_pkg
// Shared types and constants of the strided, dilated 2D convolution block.
// ----------------------------------------------------------------------------
package c2d_pkg;

    localparam int IN_CHANNELS_DEF  = 4;
    localparam int OUT_CHANNELS_DEF = 8;
    localparam int KERNEL_ROWS_DEF  = 3;
    localparam int KERNEL_COLS_DEF  = 3;
    localparam int MAX_HEIGHT_DEF   = 32;
    localparam int MAX_WIDTH_DEF    = 32;

    // Accumulator wide enough for 64 channels x 121 taps of Q16.16 products.
    localparam int ACC_W   = 48;
    // Tap coordinates: 31 * 15 + 10 * 15 fits easily.
    localparam int TAP_W   = 16;
    localparam int Q_DEPTH = 2;

    localparam logic signed [ACC_W-1:0] SAT_MAX = ACC_W'(64'sd2147483647);
    localparam logic signed [ACC_W-1:0] SAT_MIN = ACC_W'(-64'sd2147483648);

    typedef enum logic [1:0] {
        ACT_LOAD_FEAT = 2'd0,
        ACT_LOAD_WGT  = 2'd1,
        ACT_LOAD_BIAS = 2'd2,
        ACT_COMPUTE   = 2'd3
    } t_action;

    typedef enum logic [2:0] {
        CFG_STRIDE_ROWS = 3'd0,
        CFG_STRIDE_COLS = 3'd1,
        CFG_DIL_ROWS    = 3'd2,
        CFG_DIL_COLS    = 3'd3,
        CFG_IMG_HEIGHT  = 3'd4,
        CFG_IMG_WIDTH   = 3'd5
    } t_cfg_idx;

    typedef struct packed {
        t_action            action;
        logic [2:0]         out_chan;
        logic [1:0]         in_chan;
        logic [4:0]         row_pos;
        logic [4:0]         col_pos;
        logic signed [15:0] load_value;
        logic               bias_enable;
    } t_cmd;

    typedef struct packed {
        logic [3:0] stride_rows;
        logic [3:0] stride_cols;
        logic [3:0] dilation_rows;
        logic [3:0] dilation_cols;
        logic [5:0] image_height;
        logic [5:0] image_width;
    } t_cfg;

endpackage

[rtl/core/c2d_front.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// c2d_front
// Accepts requests, drops those that address nothing, holds the registers.
// ----------------------------------------------------------------------------
module c2d_front #(
    parameter int IN_CHANNELS  = c2d_pkg::IN_CHANNELS_DEF,
    parameter int OUT_CHANNELS = c2d_pkg::OUT_CHANNELS_DEF,
    parameter int KERNEL_ROWS  = c2d_pkg::KERNEL_ROWS_DEF,
    parameter int KERNEL_COLS  = c2d_pkg::KERNEL_COLS_DEF,
    parameter int MAX_HEIGHT   = c2d_pkg::MAX_HEIGHT_DEF,
    parameter int MAX_WIDTH    = c2d_pkg::MAX_WIDTH_DEF
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    output logic          o_ready,
    input  c2d_pkg::t_cmd i_cmd,
    input  logic          i_cfg_valid,
    input  logic [2:0]    i_cfg_index,
    input  logic [5:0]    i_cfg_data,
    output c2d_pkg::t_cfg o_cfg,
    input  logic          i_q_full,
    output logic          o_push,
    output c2d_pkg::t_cmd o_cmd
);

    c2d_pkg::t_cfg r_cfg;
    logic          keep;
    logic          oc_ok, ic_ok;

    assign oc_ok = 32'(i_cmd.out_chan) < 32'(OUT_CHANNELS);
    assign ic_ok = 32'(i_cmd.in_chan) < 32'(IN_CHANNELS);

    always_comb begin
        case (i_cmd.action)
            c2d_pkg::ACT_LOAD_FEAT: keep = ic_ok && 32'(i_cmd.row_pos) < 32'(MAX_HEIGHT)
                                           && 32'(i_cmd.col_pos) < 32'(MAX_WIDTH);
            c2d_pkg::ACT_LOAD_WGT:  keep = oc_ok && ic_ok
                                           && 32'(i_cmd.row_pos) < 32'(KERNEL_ROWS)
                                           && 32'(i_cmd.col_pos) < 32'(KERNEL_COLS);
            default:                keep = oc_ok;
        endcase
    end

    assign o_ready = !i_q_full;
    assign o_push  = i_valid && !i_q_full && keep;
    assign o_cmd   = i_cmd;
    assign o_cfg   = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.stride_rows   <= 4'd1;
            r_cfg.stride_cols   <= 4'd1;
            r_cfg.dilation_rows <= 4'd1;
            r_cfg.dilation_cols <= 4'd1;
            r_cfg.image_height  <= 6'd32;
            r_cfg.image_width   <= 6'd32;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                c2d_pkg::CFG_STRIDE_ROWS: r_cfg.stride_rows   <= i_cfg_data[3:0];
                c2d_pkg::CFG_STRIDE_COLS: r_cfg.stride_cols   <= i_cfg_data[3:0];
                c2d_pkg::CFG_DIL_ROWS:    r_cfg.dilation_rows <= i_cfg_data[3:0];
                c2d_pkg::CFG_DIL_COLS:    r_cfg.dilation_cols <= i_cfg_data[3:0];
                c2d_pkg::CFG_IMG_HEIGHT:  r_cfg.image_height  <= i_cfg_data;
                c2d_pkg::CFG_IMG_WIDTH:   r_cfg.image_width   <= i_cfg_data;
                default: ;
            endcase
        end
    end

endmodule

[rtl/core/c2d_queue.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// c2d_queue
// Short command queue between the front and the back.
// ----------------------------------------------------------------------------
module c2d_queue (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  c2d_pkg::t_cmd i_cmd,
    input  logic          i_pop,
    output logic          o_full,
    output logic          o_valid,
    output c2d_pkg::t_cmd o_cmd
);

    localparam int PW = (c2d_pkg::Q_DEPTH > 1) ? $clog2(c2d_pkg::Q_DEPTH) : 1;
    localparam int CW = $clog2(c2d_pkg::Q_DEPTH + 1);

    c2d_pkg::t_cmd r_mem [c2d_pkg::Q_DEPTH];
    logic [PW-1:0] r_wp, r_rp;
    logic [CW-1:0] r_count;
    logic          do_push, do_pop;

    assign o_full  = r_count == CW'(c2d_pkg::Q_DEPTH);
    assign o_valid = r_count != '0;
    assign o_cmd   = r_mem[r_rp];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wp] <= i_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp    <= '0;
            r_rp    <= '0;
            r_count <= '0;
        end else begin
            if (do_push) begin
                r_wp <= (32'(r_wp) == c2d_pkg::Q_DEPTH - 1) ? '0 : r_wp + 1'b1;
            end
            if (do_pop) begin
                r_rp <= (32'(r_rp) == c2d_pkg::Q_DEPTH - 1) ? '0 : r_rp + 1'b1;
            end
            r_count <= r_count + CW'(do_push) - CW'(do_pop);
        end
    end

endmodule

[rtl/core/c2d_back.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// c2d_back
// Stores plus a one-tap-per-cycle multiply-accumulate sequencer.
// ----------------------------------------------------------------------------
module c2d_back #(
    parameter int IN_CHANNELS  = c2d_pkg::IN_CHANNELS_DEF,
    parameter int OUT_CHANNELS = c2d_pkg::OUT_CHANNELS_DEF,
    parameter int KERNEL_ROWS  = c2d_pkg::KERNEL_ROWS_DEF,
    parameter int KERNEL_COLS  = c2d_pkg::KERNEL_COLS_DEF,
    parameter int MAX_HEIGHT   = c2d_pkg::MAX_HEIGHT_DEF,
    parameter int MAX_WIDTH    = c2d_pkg::MAX_WIDTH_DEF
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  c2d_pkg::t_cfg i_cfg,
    input  logic          i_q_valid,
    input  c2d_pkg::t_cmd i_q_cmd,
    output logic          o_pop,
    output logic          o_res_valid,
    input  logic          i_res_ready,
    output logic [2:0]    o_res_chan,
    output logic [4:0]    o_res_row,
    output logic [4:0]    o_res_col,
    output logic [31:0]   o_res_value
);

    localparam int F_DEPTH = IN_CHANNELS * MAX_HEIGHT * MAX_WIDTH;
    localparam int W_DEPTH = OUT_CHANNELS * IN_CHANNELS * KERNEL_ROWS * KERNEL_COLS;
    localparam int FA_W    = (F_DEPTH > 1) ? $clog2(F_DEPTH) : 1;
    localparam int WA_W    = (W_DEPTH > 1) ? $clog2(W_DEPTH) : 1;
    localparam int BA_W    = (OUT_CHANNELS > 1) ? $clog2(OUT_CHANNELS) : 1;
    localparam int C_W     = (IN_CHANNELS > 1) ? $clog2(IN_CHANNELS) : 1;
    localparam int KR_W    = (KERNEL_ROWS > 1) ? $clog2(KERNEL_ROWS) : 1;
    localparam int KC_W    = (KERNEL_COLS > 1) ? $clog2(KERNEL_COLS) : 1;
    localparam int TAPS    = IN_CHANNELS * KERNEL_ROWS * KERNEL_COLS;
    localparam int TAP_W   = c2d_pkg::TAP_W;
    localparam int ACC_W   = c2d_pkg::ACC_W;

    typedef enum logic [4:0] {
        ST_IDLE  = 5'b00001,
        ST_RUN   = 5'b00010,
        ST_DRAIN = 5'b00100,
        ST_BIAS  = 5'b01000,
        ST_DONE  = 5'b10000
    } t_state;

    t_state r_state, n_state;

    logic signed [15:0] r_feat_mem [F_DEPTH];
    logic signed [15:0] r_wgt_mem  [W_DEPTH];
    logic signed [15:0] r_bias_mem [OUT_CHANNELS];

    // Sequencer
    logic [C_W-1:0]   r_c;
    logic [KR_W-1:0]  r_kr;
    logic [KC_W-1:0]  r_kc;
    logic [TAP_W-1:0] r_h0, r_w0, r_hi, r_wi;
    logic [WA_W-1:0]  r_wa;
    logic [2:0]       r_oc;
    logic [4:0]       r_row, r_col;
    logic             r_bias_en;
    logic signed [15:0] r_bias_q;

    // Pipeline: read, product, accumulate
    logic signed [15:0] r_fq, r_wq;
    logic               r_rv, r_rlast, r_rok;
    logic signed [31:0] r_prod;
    logic               r_pv, r_plast;
    logic signed [ACC_W-1:0] r_acc;

    // Result register
    logic        r_out_valid;
    logic [2:0]  r_out_chan;
    logic [4:0]  r_out_row, r_out_col;
    logic [31:0] r_out_value;

    logic             start_cmp, is_load, last_tap, tap_ok, issue, out_free;
    logic [TAP_W-1:0] h_lim, w_lim;
    logic [FA_W-1:0]  f_raddr, f_waddr;
    logic [WA_W-1:0]  w_waddr;

    assign o_pop     = (r_state == ST_IDLE) && i_q_valid;
    assign start_cmp = o_pop && (i_q_cmd.action == c2d_pkg::ACT_COMPUTE);
    assign is_load   = o_pop && (i_q_cmd.action != c2d_pkg::ACT_COMPUTE);
    assign issue     = r_state == ST_RUN;
    assign out_free  = !r_out_valid || i_res_ready;

    assign h_lim = (32'(i_cfg.image_height) < 32'(MAX_HEIGHT)) ?
                   TAP_W'(i_cfg.image_height) : TAP_W'(MAX_HEIGHT);
    assign w_lim = (32'(i_cfg.image_width) < 32'(MAX_WIDTH)) ?
                   TAP_W'(i_cfg.image_width) : TAP_W'(MAX_WIDTH);
    assign tap_ok = (r_hi < h_lim) && (r_wi < w_lim);
    assign last_tap = 32'(r_c) == IN_CHANNELS - 1 && 32'(r_kr) == KERNEL_ROWS - 1
                      && 32'(r_kc) == KERNEL_COLS - 1;

    assign f_raddr = FA_W'((32'(r_c) * MAX_HEIGHT + 32'(r_hi)) * MAX_WIDTH + 32'(r_wi));
    assign f_waddr = FA_W'((32'(i_q_cmd.in_chan) * MAX_HEIGHT + 32'(i_q_cmd.row_pos))
                           * MAX_WIDTH + 32'(i_q_cmd.col_pos));
    assign w_waddr = WA_W'(((32'(i_q_cmd.out_chan) * IN_CHANNELS + 32'(i_q_cmd.in_chan))
                            * KERNEL_ROWS + 32'(i_q_cmd.row_pos)) * KERNEL_COLS
                           + 32'(i_q_cmd.col_pos));

    // Memories: one write port from loads, one registered read port for the MAC.
    always_ff @(posedge i_clk) begin
        if (is_load && i_q_cmd.action == c2d_pkg::ACT_LOAD_FEAT) begin
            r_feat_mem[f_waddr] <= i_q_cmd.load_value;
        end
        r_fq <= r_feat_mem[f_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (is_load && i_q_cmd.action == c2d_pkg::ACT_LOAD_WGT) begin
            r_wgt_mem[w_waddr] <= i_q_cmd.load_value;
        end
        r_wq <= r_wgt_mem[r_wa];
    end

    always_ff @(posedge i_clk) begin
        if (is_load && i_q_cmd.action == c2d_pkg::ACT_LOAD_BIAS) begin
            r_bias_mem[BA_W'(i_q_cmd.out_chan)] <= i_q_cmd.load_value;
        end
        if (start_cmp) begin
            r_bias_q <= r_bias_mem[BA_W'(i_q_cmd.out_chan)];
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE:  if (start_cmp) n_state = ST_RUN;
            ST_RUN:   if (last_tap) n_state = ST_DRAIN;
            ST_DRAIN: if (r_pv && r_plast) n_state = ST_BIAS;
            ST_BIAS:  n_state = ST_DONE;
            ST_DONE:  if (out_free) n_state = ST_IDLE;
            default:  n_state = ST_IDLE;
        endcase
    end

    // Tap walk: input channel outermost, kernel column innermost, which is
    // also the weight store order, so the weight address just counts.
    always_ff @(posedge i_clk) begin
        if (start_cmp) begin
            r_oc      <= i_q_cmd.out_chan;
            r_row     <= i_q_cmd.row_pos;
            r_col     <= i_q_cmd.col_pos;
            r_bias_en <= i_q_cmd.bias_enable;
            r_h0      <= TAP_W'(i_q_cmd.row_pos) * TAP_W'(i_cfg.stride_rows);
            r_w0      <= TAP_W'(i_q_cmd.col_pos) * TAP_W'(i_cfg.stride_cols);
            r_hi      <= TAP_W'(i_q_cmd.row_pos) * TAP_W'(i_cfg.stride_rows);
            r_wi      <= TAP_W'(i_q_cmd.col_pos) * TAP_W'(i_cfg.stride_cols);
            r_c       <= '0;
            r_kr      <= '0;
            r_kc      <= '0;
            r_wa      <= WA_W'(32'(i_q_cmd.out_chan) * TAPS);
        end else if (issue) begin
            r_wa <= r_wa + 1'b1;
            if (32'(r_kc) == KERNEL_COLS - 1) begin
                r_kc <= '0;
                r_wi <= r_w0;
                if (32'(r_kr) == KERNEL_ROWS - 1) begin
                    r_kr <= '0;
                    r_hi <= r_h0;
                    r_c  <= r_c + 1'b1;
                end else begin
                    r_kr <= r_kr + 1'b1;
                    r_hi <= r_hi + TAP_W'(i_cfg.dilation_rows);
                end
            end else begin
                r_kc <= r_kc + 1'b1;
                r_wi <= r_wi + TAP_W'(i_cfg.dilation_cols);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_prod <= r_rok ? r_fq * r_wq : 32'sd0;
        r_rlast <= last_tap;
        r_rok   <= tap_ok;
        r_plast <= r_rlast;
    end

    always_ff @(posedge i_clk) begin
        if (start_cmp) begin
            r_acc <= '0;
        end else if (r_pv) begin
            r_acc <= r_acc + ACC_W'(r_prod);
        end else if (r_state == ST_BIAS && r_bias_en) begin
            r_acc <= r_acc + (ACC_W'(r_bias_q) <<< 8);
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == ST_DONE && out_free) begin
            r_out_chan <= r_oc;
            r_out_row  <= r_row;
            r_out_col  <= r_col;
            if (r_acc > c2d_pkg::SAT_MAX) begin
                r_out_value <= 32'(c2d_pkg::SAT_MAX);
            end else if (r_acc < c2d_pkg::SAT_MIN) begin
                r_out_value <= 32'(c2d_pkg::SAT_MIN);
            end else begin
                r_out_value <= 32'(r_acc);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_rv        <= 1'b0;
            r_pv        <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_rv    <= issue;
            r_pv    <= r_rv;
            if (r_state == ST_DONE && out_free) begin
                r_out_valid <= 1'b1;
            end else if (i_res_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_res_valid = r_out_valid;
    assign o_res_chan  = r_out_chan;
    assign o_res_row   = r_out_row;
    assign o_res_col   = r_out_col;
    assign o_res_value = r_out_value;

    // Commands are only taken while the sequencer is free.
    a_pop_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_pop |-> r_state == ST_IDLE)
        else $error("command popped while a compute is in flight");

    // Products only arrive while a compute is running or draining.
    a_prod_in_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pv |-> (r_state == ST_RUN || r_state == ST_DRAIN))
        else $error("product outside a compute");

    // A finished compute lands in the result register on the next cycle.
    a_done_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_DONE && out_free) |=> r_out_valid && r_state == ST_IDLE)
        else $error("finished result not presented");

endmodule

[rtl/core/conv2d_strided_dilated.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// conv2d_strided_dilated
// Direct 2D convolution with stride and dilation, Q8.8 in, Q16.16 out.
// ----------------------------------------------------------------------------
// Usage:
//   Requests enter on the s_axis channel. tuser carries the action (load
//   feature, load weight, load bias, compute); tdata carries the rest.
//   Loads write one store entry and give no result. A compute request sums
//   feature times weight over all input channels and kernel taps, skipping
//   taps outside the configured image, adds the bias when asked, saturates
//   and returns one result on m_axis. Requests that address nothing are
//   dropped at the front. Registers are written on the cfg channel (always
//   ready); the user must do so only while idle, which the block does not enforce.
// Flow:
//   A load is written into its store as it is popped from the queue. A
//   compute walks every input channel and kernel tap through the read,
//   multiply and accumulate stages of the single multiply-accumulate unit,
//   then adds the bias when enabled, saturates and presents its result on m_axis.
//   A two-entry queue sits between front and back, so up to two requests are
//   still taken in while a compute runs or a result waits on a stalled receiver.
// Reset (synchronous, active low) empties the queue and the result register
//   and restores the register defaults; the stores are not cleared.
// ----------------------------------------------------------------------------
module conv2d_strided_dilated #(
    parameter int IN_CHANNELS  = c2d_pkg::IN_CHANNELS_DEF,
    parameter int OUT_CHANNELS = c2d_pkg::OUT_CHANNELS_DEF,
    parameter int KERNEL_ROWS  = c2d_pkg::KERNEL_ROWS_DEF,
    parameter int KERNEL_COLS  = c2d_pkg::KERNEL_COLS_DEF,
    parameter int MAX_HEIGHT   = c2d_pkg::MAX_HEIGHT_DEF,
    parameter int MAX_WIDTH    = c2d_pkg::MAX_WIDTH_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // out_chan[2:0], in_chan[4:3], row_pos[9:5], col_pos[14:10],
    // load_value[30:15], bias_enable[31]
    input  logic [31:0] s_axis_tdata,
    // action[1:0]
    input  logic [1:0]  s_axis_tuser,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // res_chan[2:0], res_row[7:3], res_col[12:8], res_value[44:13], zeros above
    output logic [47:0] m_axis_tdata,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [2:0]  i_cfg_index,
    input  logic [5:0]  i_cfg_data
);

    c2d_pkg::t_cmd in_cmd, q_in, q_out;
    c2d_pkg::t_cfg cfg;
    logic          push, q_full, q_valid, pop;
    logic [2:0]    res_chan;
    logic [4:0]    res_row, res_col;
    logic [31:0]   res_value;

    assign in_cmd.action      = c2d_pkg::t_action'(s_axis_tuser);
    assign in_cmd.out_chan    = s_axis_tdata[2:0];
    assign in_cmd.in_chan     = s_axis_tdata[4:3];
    assign in_cmd.row_pos     = s_axis_tdata[9:5];
    assign in_cmd.col_pos     = s_axis_tdata[14:10];
    assign in_cmd.load_value  = s_axis_tdata[30:15];
    assign in_cmd.bias_enable = s_axis_tdata[31];

    assign o_cfg_ready = 1'b1;

    c2d_front #(
        .IN_CHANNELS (IN_CHANNELS),
        .OUT_CHANNELS(OUT_CHANNELS),
        .KERNEL_ROWS (KERNEL_ROWS),
        .KERNEL_COLS (KERNEL_COLS),
        .MAX_HEIGHT  (MAX_HEIGHT),
        .MAX_WIDTH   (MAX_WIDTH)
    ) u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (s_axis_tvalid),
        .o_ready    (s_axis_tready),
        .i_cmd      (in_cmd),
        .i_cfg_valid(i_cfg_valid),
        .i_cfg_index(i_cfg_index),
        .i_cfg_data (i_cfg_data),
        .o_cfg      (cfg),
        .i_q_full   (q_full),
        .o_push     (push),
        .o_cmd      (q_in)
    );

    c2d_queue u_queue (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_push (push),
        .i_cmd  (q_in),
        .i_pop  (pop),
        .o_full (q_full),
        .o_valid(q_valid),
        .o_cmd  (q_out)
    );

    c2d_back #(
        .IN_CHANNELS (IN_CHANNELS),
        .OUT_CHANNELS(OUT_CHANNELS),
        .KERNEL_ROWS (KERNEL_ROWS),
        .KERNEL_COLS (KERNEL_COLS),
        .MAX_HEIGHT  (MAX_HEIGHT),
        .MAX_WIDTH   (MAX_WIDTH)
    ) u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg      (cfg),
        .i_q_valid  (q_valid),
        .i_q_cmd    (q_out),
        .o_pop      (pop),
        .o_res_valid(m_axis_tvalid),
        .i_res_ready(m_axis_tready),
        .o_res_chan (res_chan),
        .o_res_row  (res_row),
        .o_res_col  (res_col),
        .o_res_value(res_value)
    );

    assign m_axis_tdata = {3'b000, res_value, res_col, res_row, res_chan};

endmodule

[tb/sv/tb_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the strided, dilated 2D convolution block. Loads
// fill the feature, weight and bias stores, compute requests are checked
// field by field against a behavioral model of the convolution sum.
// ----------------------------------------------------------------------------
module tb_top;

    localparam int NIC = 4, NOC = 8, KR = 3, KC = 3, MH = 32, MW = 32;
    localparam int DRAIN_CYCLES = 60;
    // Feature rows and columns that get loaded; small positions plus a few
    // far ones so that large strides and dilations still land on data.
    localparam int N_POS = 6;
    localparam int FILL_POS [N_POS] = '{0, 1, 2, 3, 15, 30};

    typedef struct packed {
        logic signed [31:0] value;
        logic [4:0]         col;
        logic [4:0]         row;
        logic [2:0]         chan;
    } t_res;

    // One directed row: a request, plus an optional typed-in expectation.
    typedef struct {
        c2d_pkg::t_action act;
        logic [2:0]  oc;
        logic [1:0]  ic;
        logic [4:0]  rp;
        logic [4:0]  cp;
        logic [15:0] val;
        logic        be;
        bit          has_exp;
        logic [31:0] exp_val;
    } t_row;

    logic        i_clk, i_rst_n;
    logic        s_axis_tvalid, s_axis_tready;
    logic [31:0] s_axis_tdata;
    logic [1:0]  s_axis_tuser;
    logic        m_axis_tvalid, m_axis_tready;
    logic [47:0] m_axis_tdata;
    logic        i_cfg_valid, o_cfg_ready;
    logic [2:0]  i_cfg_index;
    logic [5:0]  i_cfg_data;

    conv2d_strided_dilated dut (.*);

    // Shadow state of the block.
    logic signed [15:0] feat_mem [NIC*MH*MW];
    logic signed [15:0] wgt_mem [NOC*NIC*KR*KC];
    logic signed [15:0] bias_mem [NOC];
    bit                 feat_ok [NIC*MH*MW];
    bit                 wgt_ok [NOC*NIC*KR*KC];
    bit                 bias_ok [NOC];
    c2d_pkg::t_cfg      cfg;

    t_res   pending_results[$];
    int     errors;
    int     stall_pct;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #50ms;
        $display("CHECK FAILED");
        $finish;
    end

    task automatic report(input string msg);
        $display("mismatch at %0t: %s", $realtime, msg);
        errors++;
    endtask

    // Convolution sum for one output position, saturated to Q16.16.
    function automatic logic signed [31:0] conv_sum(input logic [2:0] oc,
            input logic [4:0] rp, input logic [4:0] cp, input logic be);
        longint acc;
        int hl, wl, h, w;
        acc = 0;
        hl = (cfg.image_height < MH) ? cfg.image_height : MH;
        wl = (cfg.image_width < MW) ? cfg.image_width : MW;
        for (int c = 0; c < NIC; c++)
            for (int r = 0; r < KR; r++) begin
                h = rp * cfg.stride_rows + r * cfg.dilation_rows;
                if (h < hl)
                    for (int k = 0; k < KC; k++) begin
                        w = cp * cfg.stride_cols + k * cfg.dilation_cols;
                        if (w < wl)
                            acc += longint'(feat_mem[(c*MH+h)*MW+w])
                                 * longint'(wgt_mem[((oc*NIC+c)*KR+r)*KC+k]);
                    end
            end
        if (be)
            acc += longint'(bias_mem[oc]) * 256;
        if (acc > 64'sd2147483647)
            acc = 64'sd2147483647;
        if (acc < -64'sd2147483648)
            acc = -64'sd2147483648;
        return acc[31:0];
    endfunction

    // Every store entry that a compute with this config would read is written.
    function automatic bit all_read_defined(input logic [2:0] oc,
            input logic [4:0] rp, input logic [4:0] cp, input logic be);
        int hl, wl, h, w;
        hl = (cfg.image_height < MH) ? cfg.image_height : MH;
        wl = (cfg.image_width < MW) ? cfg.image_width : MW;
        if (be && !bias_ok[oc])
            return 0;
        for (int c = 0; c < NIC; c++)
            for (int r = 0; r < KR; r++) begin
                h = rp * cfg.stride_rows + r * cfg.dilation_rows;
                if (h < hl)
                    for (int k = 0; k < KC; k++) begin
                        w = cp * cfg.stride_cols + k * cfg.dilation_cols;
                        if (w < wl && !(feat_ok[(c*MH+h)*MW+w]
                                && wgt_ok[((oc*NIC+c)*KR+r)*KC+k]))
                            return 0;
                    end
            end
        return 1;
    endfunction

    // Update the shadow stores and queue the expected result, if any.
    task automatic predict(input t_row t);
        case (t.act)
            c2d_pkg::ACT_LOAD_FEAT: begin
                feat_mem[(t.ic*MH+t.rp)*MW+t.cp] = t.val;
                feat_ok[(t.ic*MH+t.rp)*MW+t.cp] = 1;
            end
            c2d_pkg::ACT_LOAD_WGT:
                if (t.rp < KR && t.cp < KC) begin
                    wgt_mem[((t.oc*NIC+t.ic)*KR+t.rp)*KC+t.cp] = t.val;
                    wgt_ok[((t.oc*NIC+t.ic)*KR+t.rp)*KC+t.cp] = 1;
                end
            c2d_pkg::ACT_LOAD_BIAS: begin
                bias_mem[t.oc] = t.val;
                bias_ok[t.oc] = 1;
            end
            default: begin
                t_res r;
                r.chan = t.oc;
                r.row = t.rp;
                r.col = t.cp;
                r.value = conv_sum(t.oc, t.rp, t.cp, t.be);
                if (t.has_exp && r.value !== t.exp_val)
                    report($sformatf("directed row expects %h, model gives %h",
                        t.exp_val, r.value));
                pending_results.push_back(r);
            end
        endcase
    endtask

    // Present one request at the falling edge and wait for its acceptance.
    task automatic send(input t_row t);
        s_axis_tvalid = 1'b1;
        s_axis_tuser = t.act;
        s_axis_tdata = {t.be, t.val, t.cp, t.rp, t.ic, t.oc};
        do @(posedge i_clk); while (!s_axis_tready);
        predict(t);
        @(negedge i_clk);
        s_axis_tvalid = 1'b0;
    endtask

    // Burst sender: random pauses between requests, long runs without any.
    int burst_left;
    task automatic send_paced(input t_row t);
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 30);
            repeat ($urandom_range(0, 6)) @(negedge i_clk);
        end
        burst_left--;
        send(t);
    endtask

    task automatic wait_empty();
        while (pending_results.size() != 0)
            @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(negedge i_clk);
    endtask

    task automatic write_reg(input c2d_pkg::t_cfg_idx idx, input int v);
        logic [5:0] d;
        d = 6'(v);
        i_cfg_valid = 1'b1;
        i_cfg_index = idx;
        i_cfg_data = d;
        do @(posedge i_clk); while (!o_cfg_ready);
        case (idx)
            c2d_pkg::CFG_STRIDE_ROWS: cfg.stride_rows = d[3:0];
            c2d_pkg::CFG_STRIDE_COLS: cfg.stride_cols = d[3:0];
            c2d_pkg::CFG_DIL_ROWS:    cfg.dilation_rows = d[3:0];
            c2d_pkg::CFG_DIL_COLS:    cfg.dilation_cols = d[3:0];
            c2d_pkg::CFG_IMG_HEIGHT:  cfg.image_height = d;
            default:                  cfg.image_width = d;
        endcase
        @(negedge i_clk);
        i_cfg_valid = 1'b0;
    endtask

    task automatic set_config(input int sr, input int sc, input int dr, input int dc,
            input int ih, input int iw);
        write_reg(c2d_pkg::CFG_STRIDE_ROWS, 32'(4'(sr)));
        write_reg(c2d_pkg::CFG_STRIDE_COLS, 32'(4'(sc)));
        write_reg(c2d_pkg::CFG_DIL_ROWS, 32'(4'(dr)));
        write_reg(c2d_pkg::CFG_DIL_COLS, 32'(4'(dc)));
        write_reg(c2d_pkg::CFG_IMG_HEIGHT, ih);
        write_reg(c2d_pkg::CFG_IMG_WIDTH, iw);
    endtask

    function automatic t_row mk(input c2d_pkg::t_action a, input int oc, input int ic,
            input int rp, input int cp, input int v, input int be);
        t_row t;
        t.act = a; t.oc = 3'(oc); t.ic = 2'(ic); t.rp = 5'(rp); t.cp = 5'(cp);
        t.val = 16'(v); t.be = 1'(be); t.has_exp = 0; t.exp_val = '0;
        return t;
    endfunction

    function automatic t_row mk_exp(input t_row t, input logic [31:0] e);
        t.has_exp = 1;
        t.exp_val = e;
        return t;
    endfunction

    // Receiver: its own stall pattern, with stall-free stretches.
    initial begin
        int phase;
        m_axis_tready = 1'b0;
        phase = 0;
        forever begin
            @(negedge i_clk);
            phase++;
            m_axis_tready <= (phase % 200 < 60) ? 1'b1
                           : ($urandom_range(0, 99) >= stall_pct);
        end
    end

    // Result checker.
    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            t_res got, want;
            got = m_axis_tdata[44:0];
            if (pending_results.size() == 0)
                report("result with nothing expected");
            else begin
                want = pending_results.pop_front();
                if (got.chan !== want.chan)
                    report($sformatf("chan %0d want %0d", got.chan, want.chan));
                if (got.row !== want.row)
                    report($sformatf("row %0d want %0d", got.row, want.row));
                if (got.col !== want.col)
                    report($sformatf("col %0d want %0d", got.col, want.col));
                if (got.value !== want.value)
                    report($sformatf("value %h want %h", got.value, want.value));
            end
        end
    end

    // Load the feature grid at the fill positions, every weight and every
    // bias. Mode 0 is random, any other mode is all max.
    task automatic fill_stores(input int mode);
        int fv, wv;
        for (int c = 0; c < NIC; c++)
            for (int r = 0; r < N_POS; r++)
                for (int k = 0; k < N_POS; k++) begin
                    fv = (mode == 0) ? $urandom : 16'h7fff;
                    send_paced(mk(c2d_pkg::ACT_LOAD_FEAT, $urandom, c, FILL_POS[r],
                        FILL_POS[k], fv, $urandom));
                end
        for (int o = 0; o < NOC; o++) begin
            for (int c = 0; c < NIC; c++)
                for (int r = 0; r < KR; r++)
                    for (int k = 0; k < KC; k++) begin
                        wv = (mode == 0) ? $urandom : 16'h7fff;
                        send_paced(mk(c2d_pkg::ACT_LOAD_WGT, o, c, r, k, wv, $urandom));
                    end
            send_paced(mk(c2d_pkg::ACT_LOAD_BIAS, o, $urandom, $urandom, $urandom,
                (mode == 0) ? $urandom : 16'h7fff, $urandom));
        end
    endtask

    t_row directed[$];
    int   computes;

    initial begin
        t_row t;
        errors = 0;
        stall_pct = 30;
        burst_left = 0;
        i_rst_n = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = '0;
        s_axis_tuser = c2d_pkg::ACT_LOAD_FEAT;
        i_cfg_valid = 1'b0;
        i_cfg_index = c2d_pkg::CFG_STRIDE_ROWS;
        i_cfg_data = '0;
        cfg = '{4'd1, 4'd1, 4'd1, 4'd1, 6'd32, 6'd32};
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // Directed part: reset config, tiny image set by hand, then extremes.
        directed.push_back(mk(c2d_pkg::ACT_LOAD_FEAT, 0, 0, 0, 0, 16'h0100, 0));
        directed.push_back(mk(c2d_pkg::ACT_LOAD_WGT, 0, 0, 0, 0, 16'h0100, 0));
        directed.push_back(mk(c2d_pkg::ACT_LOAD_BIAS, 0, 0, 0, 0, 16'h0200, 0));
        // The other input channels hold zero at the single tap.
        for (int c = 1; c < NIC; c++) begin
            directed.push_back(mk(c2d_pkg::ACT_LOAD_FEAT, 0, c, 0, 0, 0, 0));
            directed.push_back(mk(c2d_pkg::ACT_LOAD_WGT, 0, c, 0, 0, 0, 0));
        end
        // Ignored loads: kernel position beyond the kernel.
        directed.push_back(mk(c2d_pkg::ACT_LOAD_WGT, 0, 0, 31, 31, 16'h1234, 1));
        directed.push_back(mk(c2d_pkg::ACT_LOAD_WGT, 7, 3, 3, 0, 16'hffff, 1));
        foreach (directed[i]) send(directed[i]);
        wait_empty();
        // 1x1 image: one tap, 1.0 * 1.0, plus bias 2.0 when enabled.
        set_config(1, 1, 1, 1, 1, 1);
        send(mk_exp(mk(c2d_pkg::ACT_COMPUTE, 0, 0, 0, 0, 0, 0), 32'h0001_0000));
        send(mk_exp(mk(c2d_pkg::ACT_COMPUTE, 0, 3, 0, 0, 16'hffff, 1), 32'h0003_0000));
        wait_empty();
        // Zero image size skips every tap.
        set_config(0, 0, 0, 0, 0, 0);
        send(mk_exp(mk(c2d_pkg::ACT_COMPUTE, 0, 0, 31, 31, 0, 0), 32'h0));
        send(mk_exp(mk(c2d_pkg::ACT_COMPUTE, 0, 0, 0, 0, 0, 1), 32'h0002_0000));
        wait_empty();

        // Saturation high: all max features and weights plus max bias.
        set_config(1, 1, 1, 1, 31, 31);
        fill_stores(1);
        for (int o = 0; o < NOC; o++)
            send(mk_exp(mk(c2d_pkg::ACT_COMPUTE, o, 0, 0, 0, 0, 1), 32'h7fff_ffff));
        // Corner position: only four taps, still above the top.
        send(mk_exp(mk(c2d_pkg::ACT_COMPUTE, 7, 0, 30, 30, 0, 0), 32'h7fff_ffff));
        wait_empty();
        // Saturation low: minimum weights on one output channel.
        for (int c = 0; c < NIC; c++)
            for (int r = 0; r < KR; r++)
                for (int k = 0; k < KC; k++)
                    send_paced(mk(c2d_pkg::ACT_LOAD_WGT, 3, c, r, k, 16'h8000, 0));
        send(mk_exp(mk(c2d_pkg::ACT_COMPUTE, 3, 0, 1, 1, 0, 0), 32'h8000_0000));
        wait_empty();

        // Random part over several configurations, extremes included.
        fill_stores(0);
        wait_empty();
        computes = 0;
        for (int ph = 0; ph < 8; ph++) begin
            case (ph)
                0: set_config(1, 1, 1, 1, 32, 32);
                1: set_config(15, 15, 15, 15, 63, 63);
                2: set_config(0, 0, 0, 0, 32, 32);
                3: set_config(8, 8, 8, 8, 1, 1);
                default: set_config($urandom, $urandom, $urandom, $urandom,
                    $urandom, $urandom);
            endcase
            stall_pct = $urandom_range(0, 80);
            repeat (75) begin
                int pick, tries;
                pick = $urandom_range(0, 9);
                if (pick < 6) begin
                    t = mk(c2d_pkg::ACT_COMPUTE, $urandom, $urandom, $urandom, $urandom,
                        $urandom, $urandom);
                    if (t.be && !bias_ok[t.oc]) t.be = 0;
                    // Pull the position in (at most 16 tries) to loaded data.
                    tries = 0;
                    while (!all_read_defined(t.oc, t.rp, t.cp, t.be) && tries < 16) begin
                        t.rp = 5'($urandom_range(0, 3));
                        t.cp = 5'($urandom_range(0, 3));
                        tries++;
                    end
                    if (all_read_defined(t.oc, t.rp, t.cp, t.be))
                        computes++;
                    else
                        t.act = c2d_pkg::ACT_LOAD_FEAT;
                end else
                    t = mk(c2d_pkg::t_action'(pick - 6 > 2 ? 2 : pick - 6), $urandom,
                        $urandom, $urandom, $urandom, $urandom, $urandom);
                send_paced(t);
            end
            // Hold off until the block has drained once per phase.
            wait_empty();
        end

        wait_empty();
        if (errors == 0 && pending_results.size() == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end
endmodule
